// File: rtl/fpcc_pkg.sv
// Shared types, constants and helpers for the farthest pair collinearity check.
// Used by the top level and by its port checker; depends on nothing.
`default_nettype none

package fpcc_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int MIN_POINTS     = 4;

	// Verdict codes on the result port
	localparam logic [1:0] VERDICT_FEW       = 2'd0;
	localparam logic [1:0] VERDICT_COLLINEAR = 2'd1;
	localparam logic [1:0] VERDICT_OK        = 2'd2;

	typedef struct packed {
		logic [15:0] z;
		logic [15:0] y;
		logic [15:0] x;
	} point_t;

	// Sign-extend a Q8.8 coordinate by one bit so a difference cannot wrap
	function automatic logic signed [16:0] ext17(input logic [15:0] v);
		return $signed({v[15], v});
	endfunction

endpackage

`default_nettype wire

// File: rtl/farthest_pair_collinearity_check.sv
// Farthest pair of a 3D point set with a collinearity verdict.
// A point without the last mark is taken and the block stays ready. The closing point
//   starts a pair scan and, for n >= 4 stored points, a line scan, both paced by the
//   single read port of the point memory, which delivers one point per cycle.
// Throughput: one beat per cycle while loading; one result per set, done high 1 cycle.
// Reset (arst_n low): point count and overflow flag clear, the block goes idle;
//   the point memory is not cleared. The receiver cannot stall the result.
`default_nettype none

module farthest_pair_collinearity_check #(
	parameter int MAX_POINTS = fpcc_pkg::MAX_POINTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output      logic                busy,
	input  wire logic signed [15:0]  coord_x,
	input  wire logic signed [15:0]  coord_y,
	input  wire logic signed [15:0]  coord_z,
	input  wire logic                is_last,
	output      logic                done,
	output      logic signed [15:0]  first_x,
	output      logic signed [15:0]  first_y,
	output      logic signed [15:0]  first_z,
	output      logic signed [15:0]  second_x,
	output      logic signed [15:0]  second_y,
	output      logic signed [15:0]  second_z,
	output      logic [33:0]         max_sq_dist,
	output      logic [1:0]          verdict,
	output      logic [8:0]          point_total,
	output      logic                overflowed
);

	import fpcc_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	// Sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ROW    = 3'd1;  // read the outer point of a row
	localparam logic [2:0] ST_COL    = 3'd2;  // stream the inner points of a row
	localparam logic [2:0] ST_SDRAIN = 3'd3;  // let the distance pipe empty
	localparam logic [2:0] ST_LINE   = 3'd4;  // stream all points for cross products
	localparam logic [2:0] ST_LDRAIN = 3'd5;  // let the cross product pipe empty
	localparam logic [2:0] ST_OUT    = 3'd6;  // present the result beat

	// Tag of what a memory read (and the stage it feeds) carries
	localparam logic [1:0] RD_NONE = 2'd0;
	localparam logic [1:0] RD_ROW  = 2'd1;
	localparam logic [1:0] RD_COL  = 2'd2;
	localparam logic [1:0] RD_LINE = 2'd3;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] last_idx;
	logic          accept;
	logic          full;
	logic          pipe_empty;

	// Point memory: one write port for loading, one read port for the scans
	point_t        mem [MAX_POINTS];
	point_t        rdata_q;
	logic          re;
	logic [AW-1:0] raddr;
	logic [1:0]    rk_d;
	logic [1:0]    rk_q;

	// Scan pipeline
	point_t                  row_q;
	logic [1:0]              kind_s1;
	logic [1:0]              kind_s2;
	logic signed [16:0]      dx_s1, dy_s1, dz_s1;
	logic signed [16:0]      ux_s1, uy_s1, uz_s1;
	logic signed [16:0]      vx_s1, vy_s1, vz_s1;
	point_t                  a_s1, b_s1, a_s2, b_s2;
	logic signed [33:0]      sqx, sqy, sqz;
	logic [31:0]             sqx_s2, sqy_s2, sqz_s2;
	logic signed [33:0]      pyz, pzy, pzx, pxz, pxy, pyx;
	logic signed [33:0]      pyz_s2, pzy_s2, pzx_s2, pxz_s2, pxy_s2, pyx_s2;
	logic [33:0]             dsum;

	// Running result
	logic [33:0] best_q;
	point_t      a_q;
	point_t      b_q;
	logic        col_q;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign full       = (cnt_q == CW'(MAX_POINTS));
	assign last_idx   = cnt_q - CW'(1);
	assign pipe_empty = (rk_q == RD_NONE) && (kind_s1 == RD_NONE) && (kind_s2 == RD_NONE);

	// Read address and tag follow the sequencer state
	always_comb begin
		re    = 1'b0;
		raddr = '0;
		rk_d  = RD_NONE;
		unique case (state_q)
			ST_ROW: begin
				re    = 1'b1;
				raddr = i_q[AW-1:0];
				rk_d  = RD_ROW;
			end
			ST_COL: begin
				re    = 1'b1;
				raddr = j_q[AW-1:0];
				rk_d  = RD_COL;
			end
			ST_LINE: begin
				re    = 1'b1;
				raddr = i_q[AW-1:0];
				rk_d  = RD_LINE;
			end
			default: begin
				re    = 1'b0;
			end
		endcase
	end

	// Write only while idle, read only while busy: the two never meet
	always_ff @(posedge clk) begin
		if (accept && !full) begin
			mem[cnt_q[AW-1:0]] <= '{z: coord_z, y: coord_y, x: coord_x};
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			rk_q    <= RD_NONE;
			kind_s1 <= RD_NONE;
			kind_s2 <= RD_NONE;
		end else begin
			rk_q    <= rk_d;
			kind_s1 <= (rk_q == RD_ROW) ? RD_NONE : rk_q;
			kind_s2 <= kind_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// drop the point when the store is full, but keep the flag
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (is_last) begin
							i_q     <= '0;
							state_q <= ST_ROW;
						end
					end
				end
				ST_ROW: begin
					j_q     <= '0;
					state_q <= ST_COL;
				end
				ST_COL: begin
					j_q <= j_q + CW'(1);
					if (j_q == last_idx) begin
						if (i_q == last_idx) begin
							state_q <= ST_SDRAIN;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= ST_ROW;
						end
					end
				end
				ST_SDRAIN: begin
					if (pipe_empty) begin
						i_q     <= '0;
						state_q <= (cnt_q < CW'(MIN_POINTS)) ? ST_OUT : ST_LINE;
					end
				end
				ST_LINE: begin
					i_q <= i_q + CW'(1);
					if (i_q == last_idx) begin
						state_q <= ST_LDRAIN;
					end
				end
				ST_LDRAIN: begin
					if (pipe_empty) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// result beat goes out now; empty the store for the next set
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Stage 2 products; full 34-bit signed context keeps them exact
	assign sqx = dx_s1 * dx_s1;
	assign sqy = dy_s1 * dy_s1;
	assign sqz = dz_s1 * dz_s1;
	assign pyz = uy_s1 * vz_s1;
	assign pzy = uz_s1 * vy_s1;
	assign pzx = uz_s1 * vx_s1;
	assign pxz = ux_s1 * vz_s1;
	assign pxy = ux_s1 * vy_s1;
	assign pyx = uy_s1 * vx_s1;

	assign dsum = 34'(sqx_s2) + 34'(sqy_s2) + 34'(sqz_s2);

	// Datapath: payload only, no reset
	always_ff @(posedge clk) begin
		// hold the outer point of the current row
		if (rk_q == RD_ROW) begin
			row_q <= rdata_q;
		end

		// stage 1: differences
		if (rk_q == RD_COL) begin
			dx_s1 <= ext17(row_q.x) - ext17(rdata_q.x);
			dy_s1 <= ext17(row_q.y) - ext17(rdata_q.y);
			dz_s1 <= ext17(row_q.z) - ext17(rdata_q.z);
			a_s1  <= row_q;
			b_s1  <= rdata_q;
		end
		if (rk_q == RD_LINE) begin
			ux_s1 <= ext17(a_q.x) - ext17(rdata_q.x);
			uy_s1 <= ext17(a_q.y) - ext17(rdata_q.y);
			uz_s1 <= ext17(a_q.z) - ext17(rdata_q.z);
			vx_s1 <= ext17(b_q.x) - ext17(rdata_q.x);
			vy_s1 <= ext17(b_q.y) - ext17(rdata_q.y);
			vz_s1 <= ext17(b_q.z) - ext17(rdata_q.z);
		end

		// stage 2: squares or cross product terms
		if (kind_s1 == RD_COL) begin
			sqx_s2 <= sqx[31:0];
			sqy_s2 <= sqy[31:0];
			sqz_s2 <= sqz[31:0];
			a_s2   <= a_s1;
			b_s2   <= b_s1;
		end
		if (kind_s1 == RD_LINE) begin
			pyz_s2 <= pyz;
			pzy_s2 <= pzy;
			pzx_s2 <= pzx;
			pxz_s2 <= pxz;
			pxy_s2 <= pxy;
			pyx_s2 <= pyx;
		end

		// stage 3: a closing point resets the result; otherwise keep the first strictly
		// greater distance and clear the collinear flag on any nonzero cross product
		if (accept && is_last) begin
			best_q <= '0;
			a_q    <= '0;
			b_q    <= '0;
			col_q  <= 1'b1;
		end else begin
			if ((kind_s2 == RD_COL) && (dsum > best_q)) begin
				best_q <= dsum;
				a_q    <= a_s2;
				b_q    <= b_s2;
			end
			if ((kind_s2 == RD_LINE) &&
			    ((pyz_s2 != pzy_s2) || (pzx_s2 != pxz_s2) || (pxy_s2 != pyx_s2))) begin
				col_q <= 1'b0;
			end
		end
	end

	// Result beat
	assign done        = (state_q == ST_OUT);
	assign first_x     = a_q.x;
	assign first_y     = a_q.y;
	assign first_z     = a_q.z;
	assign second_x    = b_q.x;
	assign second_y    = b_q.y;
	assign second_z    = b_q.z;
	assign max_sq_dist = best_q;
	assign overflowed  = ovf_q;

	always_comb begin
		if (cnt_q < CW'(MIN_POINTS)) begin
			verdict = VERDICT_FEW;
		end else if (col_q) begin
			verdict = VERDICT_COLLINEAR;
		end else begin
			verdict = VERDICT_OK;
		end
		// saturate the count at the width of the port
		if (32'(cnt_q) > 32'd511) begin
			point_total = 9'd511;
		end else begin
			point_total = 9'(cnt_q);
		end
	end

endmodule

`default_nettype wire

// File: rtl/fpcc_checker.sv
// Port-level checker for the farthest pair collinearity check, bound to the top level.
// Depends on fpcc_pkg for the verdict codes and point limit.
`default_nettype none

module fpcc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        is_last,
	input wire logic        done,
	input wire logic [15:0] first_x,
	input wire logic [15:0] first_y,
	input wire logic [15:0] first_z,
	input wire logic [33:0] max_sq_dist,
	input wire logic [1:0]  verdict,
	input wire logic [8:0]  point_total
);

	import fpcc_pkg::*;

	// A result beat appears only while the block is busy with a set
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat while idle");

	// After the result beat the block is ready again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block not idle after result beat");

	// A point without the last mark gives no result and leaves the block ready
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !is_last) |=> !busy && !done)
		else $error("loading beat stalled the block");

	// A closing point starts a scan that cannot end in the next cycle
	a_scan_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && is_last) |=> busy && !done)
		else $error("scan did not start");

	// Verdict agrees with the point count and is never code 3, and a zero distance gives a zero first point
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (((point_total < 9'(MIN_POINTS)) == (verdict == VERDICT_FEW)) &&
		          (verdict != 2'd3) &&
		          ((max_sq_dist != 34'd0) ||
		           ((first_x == 16'd0) && (first_y == 16'd0) && (first_z == 16'd0)))))
		else $error("inconsistent result beat");

endmodule

bind farthest_pair_collinearity_check fpcc_checker u_fpcc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.is_last     (is_last),
	.done        (done),
	.first_x     (first_x),
	.first_y     (first_y),
	.first_z     (first_z),
	.max_sq_dist (max_sq_dist),
	.verdict     (verdict),
	.point_total (point_total)
);

`default_nettype wire
